/* hdl/fmatb_pkg.sv */
// Shared types and constants for the four-member adjacency table builder.
// No dependencies; imported by fmatb_regs, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package fmatb_pkg;

  localparam int TAG_W   = 12;
  localparam int IDX_W   = 12;
  localparam int TYPE_W  = 6;
  localparam int ADDR_W  = 16;
  localparam int SLOT_W  = 5;
  localparam int ST_W    = 3;
  localparam int REQ_W   = 2;
  localparam int ROLE_W  = 2;
  localparam int PC_W    = 13;
  localparam int TC_W    = 7;
  localparam int TH_W    = 5;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GROUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_REPEAT   = 3'd2;
  localparam logic [ST_W-1:0] ST_TYPE     = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

  localparam logic [ROLE_W-1:0] ROLE_LAST = 2'd3;

  localparam logic [1:0] REG_PCOUNT  = 2'd0;
  localparam logic [1:0] REG_TCOUNT  = 2'd1;
  localparam logic [1:0] REG_THEIGHT = 2'd2;

  localparam logic [PC_W-1:0] PC_RST = 13'd4096;
  localparam logic [TC_W-1:0] TC_RST = 7'd1;
  localparam logic [TH_W-1:0] TH_RST = 5'd16;

  localparam logic [SLOT_W-1:0] CNT_MAX = 5'd31;

  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [PC_W-1:0] particle_count;
    logic [TC_W-1:0] type_count;
    logic [TH_W-1:0] table_height;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/fmatb_regs.sv */
// APB-style configuration registers: particle count, type count, table height.
// Depends on fmatb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmatb_regs (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [fmatb_pkg::PADDR_W-1:0] paddr,
  input  wire  [fmatb_pkg::PDATA_W-1:0] pwdata,
  output logic [fmatb_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output fmatb_pkg::cfg_t               cfg
);
  import fmatb_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.particle_count <= PC_RST;
      cfg_r.type_count     <= TC_RST;
      cfg_r.table_height   <= TH_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PCOUNT:  cfg_r.particle_count <= pwdata[PC_W-1:0];
        REG_TCOUNT:  cfg_r.type_count     <= pwdata[TC_W-1:0];
        REG_THEIGHT: cfg_r.table_height   <= pwdata[TH_W-1:0];
        default:     cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PCOUNT:  prdata = PDATA_W'(cfg_r.particle_count);
      REG_TCOUNT:  prdata = PDATA_W'(cfg_r.type_count);
      REG_THEIGHT: prdata = PDATA_W'(cfg_r.table_height);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/four_member_adjacency_table_build.sv */
// Top level of the four-member adjacency table builder: tag map memory,
// slot counter memory, group sequencer and result register.
// Depends on fmatb_pkg and fmatb_regs.
//
//   port group   direction  transaction
//   in_*         sink       one request: load map entry, add group or clear
//   out_*        source     one table write / error result, out_last on final
//   psel..pready slave      register write or read, index at paddr[3:2]
//
// A group passes from acceptance through the check, the tag map reads and index
// reduction and the counter read-modify-writes, then gives one result per cycle
// while out_stall is low; an error goes from the check to a lone result. The
// single port of each memory sets this. Load and unused codes need no further
// steps; a clear sweeps every counter memory entry to zero, holding in_stall.
// After reset the same sweep runs over every entry before in_stall drops.
// Results wait in an output register; out_stall holds it and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module four_member_adjacency_table_build #(
  parameter int MAX_PARTICLES = 4096,
  parameter int MAX_HEIGHT    = 16,
  parameter int MAX_TYPES     = 64
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [fmatb_pkg::REQ_W-1:0]   in_req_type,
  input  wire  [fmatb_pkg::TAG_W-1:0]   in_tag_a,
  input  wire  [fmatb_pkg::TAG_W-1:0]   in_tag_b,
  input  wire  [fmatb_pkg::TAG_W-1:0]   in_tag_c,
  input  wire  [fmatb_pkg::TAG_W-1:0]   in_tag_d,
  input  wire  [fmatb_pkg::TYPE_W-1:0]  in_group_type,
  input  wire  [fmatb_pkg::IDX_W-1:0]   in_map_index,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic                          out_write_valid,
  output logic [fmatb_pkg::ADDR_W-1:0]  out_write_addr,
  output logic [fmatb_pkg::IDX_W-1:0]   out_other_first,
  output logic [fmatb_pkg::IDX_W-1:0]   out_other_second,
  output logic [fmatb_pkg::IDX_W-1:0]   out_other_third,
  output logic [fmatb_pkg::TYPE_W-1:0]  out_entry_type,
  output logic [fmatb_pkg::ROLE_W-1:0]  out_member_role,
  output logic [fmatb_pkg::ST_W-1:0]    out_status,
  output logic [fmatb_pkg::SLOT_W-1:0]  out_max_slots,
  output logic                          out_last,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [fmatb_pkg::PADDR_W-1:0] paddr,
  input  wire  [fmatb_pkg::PDATA_W-1:0] pwdata,
  output logic [fmatb_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import fmatb_pkg::*;

  localparam int CW     = $clog2(MAX_PARTICLES);
  localparam int XW     = (CW > TAG_W) ? CW : TAG_W;
  localparam int RCP_SH = 24;
  localparam int RCP_W  = 25;
  localparam int PROD_W = IDX_W + RCP_W;
  localparam int RM_W   = 30;
  localparam int AP_W   = 18;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((1 << RCP_SH) + MAX_PARTICLES - 1) / MAX_PARTICLES);
  localparam logic [CW-1:0] SWEEP_LAST = CW'(MAX_PARTICLES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_COUNT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [2:0] FETCH_END = 3'd5;
  localparam logic [2:0] COUNT_END = 3'd4;

  cfg_t cfg;

  fmatb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // control
  logic [2:0]        state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [CW-1:0]     sweep_r, sweep_nxt;
  slot_t             rmax_r, rmax_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  tag_t              tag_r [4];
  logic [TYPE_W-1:0] gtype_r;
  logic [ST_W-1:0]   err_r;
  idx_t              idx_r [4];
  logic [CW-1:0]     cix_r [4];
  slot_t             slot_r [4];
  slot_t             cnew_r;
  idx_t              tmem_q, idxs_r, q_r;
  slot_t             cmem_q;

  idx_t              tmem [MAX_PARTICLES];
  slot_t             cmem [MAX_PARTICLES];

  logic              in_acc, out_load;
  logic [PC_W-1:0]   n_c;
  logic [TC_W-1:0]   nt_c;
  logic [TH_W-1:0]   h_c;
  logic [ST_W-1:0]   chk_st;
  logic              rng_bad, rep_bad;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;

  assign n_c  = (32'(cfg.particle_count) > MAX_PARTICLES) ? PC_W'(MAX_PARTICLES)
                                                         : cfg.particle_count;
  assign nt_c = (32'(cfg.type_count) > MAX_TYPES) ? TC_W'(MAX_TYPES) : cfg.type_count;
  assign h_c  = (32'(cfg.table_height) > MAX_HEIGHT) ? TH_W'(MAX_HEIGHT)
                                                     : cfg.table_height;

  // group checks
  always_comb begin
    rng_bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (PC_W'(tag_r[i]) >= n_c) rng_bad = 1'b1;
    end
    rep_bad = (tag_r[0] == tag_r[1]) || (tag_r[0] == tag_r[2]) ||
              (tag_r[0] == tag_r[3]) || (tag_r[1] == tag_r[2]) ||
              (tag_r[1] == tag_r[3]) || (tag_r[2] == tag_r[3]);
    if (rng_bad)                        chk_st = ST_RANGE;
    else if (rep_bad)                   chk_st = ST_REPEAT;
    else if (TC_W'(gtype_r) >= nt_c)    chk_st = ST_TYPE;
    else                                chk_st = ST_OK;
  end

  // tag map memory
  logic [XW-1:0] ld_x, rd_x;
  tag_t          rd_tag;
  logic          ld_en;

  always_comb begin
    rd_tag = tag_r[0];
    for (int i = 0; i < 4; i++) begin
      if (step_r[1:0] == 2'(i)) rd_tag = tag_r[i];
    end
  end

  assign ld_x  = XW'(in_tag_a);
  assign rd_x  = XW'(rd_tag);
  assign ld_en = in_acc && (in_req_type == REQ_LOAD) && (32'(in_tag_a) < MAX_PARTICLES);

  always_ff @(posedge clk) begin
    if (ld_en) tmem[ld_x[CW-1:0]] <= in_map_index;
    tmem_q <= tmem[rd_x[CW-1:0]];
  end

  // index reduction modulo MAX_PARTICLES: reciprocal multiply, then subtract
  logic [PROD_W-1:0] prod;
  logic [RM_W-1:0]   qm, rem_full;

  assign prod     = PROD_W'(tmem_q) * PROD_W'(RECIP);
  assign qm       = RM_W'(q_r) * RM_W'(MAX_PARTICLES);
  assign rem_full = RM_W'(idxs_r) - qm;

  always_ff @(posedge clk) begin
    q_r    <= prod[RCP_SH +: IDX_W];
    idxs_r <= tmem_q;
    for (int i = 0; i < 4; i++) begin
      if (state_r == S_FETCH && step_r == 3'(i + 2)) begin
        idx_r[i] <= idxs_r;
        cix_r[i] <= CW'(rem_full[IDX_W-1:0]);
      end
    end
  end

  // slot counter read-modify-write
  logic [1:0]    pm;
  logic [CW-1:0] rd_cix, cur_cix, prev_cix;
  logic          fwd, hit, cnt_we;
  slot_t         hslot, rd_cnt, cnew;

  assign pm = 2'(step_r - 3'd1);

  always_comb begin
    rd_cix   = cix_r[0];
    cur_cix  = cix_r[0];
    prev_cix = cix_r[0];
    for (int i = 0; i < 4; i++) begin
      if (step_r[1:0] == 2'(i))    rd_cix   = cix_r[i];
      if (pm == 2'(i))             cur_cix  = cix_r[i];
      if (pm == 2'(i + 1))         prev_cix = cix_r[i];
    end
    hit   = 1'b0;
    hslot = '0;
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < pm && cix_r[j] == cur_cix) begin
        hit   = 1'b1;
        hslot = slot_r[j];
      end
    end
    fwd    = (pm != 2'd0) && (cur_cix == prev_cix);
    rd_cnt = fwd ? cnew_r : cmem_q;
    cnew   = (rd_cnt < CNT_MAX) ? rd_cnt + 5'd1 : CNT_MAX;
  end

  assign cnt_we = (state_r == S_COUNT) && (step_r != 3'd0);

  always_ff @(posedge clk) begin
    if (state_r == S_SWEEP)  cmem[sweep_r] <= '0;
    else if (cnt_we)         cmem[cur_cix] <= cnew;
    cmem_q <= cmem[rd_cix];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnew_r <= cnew;
      for (int i = 0; i < 4; i++) begin
        if (pm == 2'(i)) slot_r[i] <= hit ? hslot : rd_cnt;
      end
    end
  end

  // result assembly
  idx_t          e_idx;
  slot_t         e_slot;
  logic          e_wv;
  logic [AP_W-1:0] e_sum;

  always_comb begin
    e_idx  = idx_r[0];
    e_slot = slot_r[0];
    for (int i = 0; i < 4; i++) begin
      if (step_r[1:0] == 2'(i)) begin
        e_idx  = idx_r[i];
        e_slot = slot_r[i];
      end
    end
    e_wv  = (TH_W'(e_slot) < h_c);
    e_sum = AP_W'(e_slot) * AP_W'(n_c) + AP_W'(e_idx);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r[0] <= in_tag_a;
      tag_r[1] <= in_tag_b;
      tag_r[2] <= in_tag_c;
      tag_r[3] <= in_tag_d;
      gtype_r  <= in_group_type;
    end
    if (state_r == S_CHECK) err_r <= chk_st;
    if (state_r == S_EMIT && out_load) begin
      out_max_slots <= rmax_r;
      if (err_r != ST_OK) begin
        out_write_valid  <= 1'b0;
        out_write_addr   <= '0;
        out_other_first  <= '0;
        out_other_second <= '0;
        out_other_third  <= '0;
        out_entry_type   <= '0;
        out_member_role  <= '0;
        out_status       <= err_r;
        out_last         <= 1'b1;
      end else begin
        out_write_valid  <= e_wv;
        out_write_addr   <= e_wv ? e_sum[ADDR_W-1:0] : '0;
        out_other_first  <= (step_r[1:0] == 2'd0) ? idx_r[1] : idx_r[0];
        out_other_second <= (step_r[1:0] <= 2'd1) ? idx_r[2] : idx_r[1];
        out_other_third  <= (step_r[1:0] <= 2'd2) ? idx_r[3] : idx_r[2];
        out_entry_type   <= gtype_r;
        out_member_role  <= step_r[1:0];
        out_status       <= e_wv ? ST_OK : ST_OVERFLOW;
        out_last         <= (step_r[1:0] == ROLE_LAST);
      end
    end
  end

  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sweep_nxt     = sweep_r;
    rmax_nxt      = rmax_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_acc) begin
          case (in_req_type)
            REQ_GROUP: state_nxt = S_CHECK;
            REQ_CLEAR: begin
              state_nxt = S_SWEEP;
              sweep_nxt = '0;
            end
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        rmax_nxt  = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_LAST) state_nxt = S_IDLE;
      end
      S_CHECK: begin
        step_nxt  = '0;
        state_nxt = (chk_st != ST_OK) ? S_EMIT : S_FETCH;
      end
      S_FETCH: begin
        step_nxt = step_r + 3'd1;
        if (step_r == FETCH_END) begin
          step_nxt  = '0;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        step_nxt = step_r + 3'd1;
        if (cnt_we && cnew > rmax_r) rmax_nxt = cnew;
        if (step_r == COUNT_END) begin
          step_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          step_nxt      = step_r + 3'd1;
          if (err_r != ST_OK || step_r[1:0] == ROLE_LAST) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      step_r      <= '0;
      sweep_r     <= '0;
      rmax_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sweep_r     <= sweep_nxt;
      rmax_r      <= rmax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/fmatb_check.sv */
// Port-level checks on the result channel of the adjacency table builder,
// bound to four_member_adjacency_table_build. Depends on fmatb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmatb_check (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire                          out_write_valid,
  input wire [fmatb_pkg::ADDR_W-1:0]  out_write_addr,
  input wire [fmatb_pkg::ROLE_W-1:0]  out_member_role,
  input wire [fmatb_pkg::ST_W-1:0]    out_status,
  input wire                          out_last
);
  import fmatb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_addr) &&
                               $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_status == ST_OK)
    else $error("table write with nonzero status");

  a_ovf_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> !out_write_valid && out_write_addr == '0)
    else $error("overflow result carries a write");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid && out_status != ST_OVERFLOW |->
      out_last && out_member_role == '0)
    else $error("error result is not a lone final transaction");

  a_last_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && (out_status == ST_OK || out_status == ST_OVERFLOW) |->
      out_member_role == ROLE_LAST)
    else $error("final member result has wrong role");

endmodule

bind four_member_adjacency_table_build fmatb_check u_fmatb_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_write_valid (out_write_valid),
  .out_write_addr  (out_write_addr),
  .out_member_role (out_member_role),
  .out_status      (out_status),
  .out_last        (out_last)
);

`default_nettype wire

/* tb/sv/four_member_adjacency_table_build_test.sv */
// Self-checking testbench for four_member_adjacency_table_build: a queue-fed driver,
// an in-line predictor of the table writes and a clocked monitor with random stalls.
// Depends on fmatb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module four_member_adjacency_table_build_test;
  import fmatb_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  localparam int HEIGHT_CAP = 16;
  localparam int TYPE_CAP = 64;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 100;
  localparam int SETTLE_LIMIT = 200000;
  localparam int PRESSURE_AT = 80;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic [REQ_W-1:0]  req_type;
    tag_t              tag_a;
    tag_t              tag_b;
    tag_t              tag_c;
    tag_t              tag_d;
    logic [TYPE_W-1:0] group_type;
    idx_t              map_index;
  } request_t;

  typedef struct {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    idx_t              other_first;
    idx_t              other_second;
    idx_t              other_third;
    logic [TYPE_W-1:0] entry_type;
    logic [ROLE_W-1:0] member_role;
    logic [ST_W-1:0]   status;
    slot_t             max_slots;
    logic              last;
  } table_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  in_req_type = '0;
  tag_t              in_tag_a = '0;
  tag_t              in_tag_b = '0;
  tag_t              in_tag_c = '0;
  tag_t              in_tag_d = '0;
  logic [TYPE_W-1:0] in_group_type = '0;
  idx_t              in_map_index = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_write_valid;
  logic [ADDR_W-1:0] out_write_addr;
  idx_t              out_other_first;
  idx_t              out_other_second;
  idx_t              out_other_third;
  logic [TYPE_W-1:0] out_entry_type;
  logic [ROLE_W-1:0] out_member_role;
  logic [ST_W-1:0]   out_status;
  slot_t             out_max_slots;
  logic              out_last;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  four_member_adjacency_table_build #(
    .MAX_PARTICLES(TABLE_DEPTH),
    .MAX_HEIGHT(HEIGHT_CAP),
    .MAX_TYPES(TYPE_CAP)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_tag_a(in_tag_a),
    .in_tag_b(in_tag_b),
    .in_tag_c(in_tag_c),
    .in_tag_d(in_tag_d),
    .in_group_type(in_group_type),
    .in_map_index(in_map_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_write_valid(out_write_valid),
    .out_write_addr(out_write_addr),
    .out_other_first(out_other_first),
    .out_other_second(out_other_second),
    .out_other_third(out_other_third),
    .out_entry_type(out_entry_type),
    .out_member_role(out_member_role),
    .out_status(out_status),
    .out_max_slots(out_max_slots),
    .out_last(out_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register shadow, shared by the request generator and the predictor
  logic [PC_W-1:0] cfg_pcount = PC_RST;
  logic [TC_W-1:0] cfg_tcount = TC_RST;
  logic [TH_W-1:0] cfg_theight = TH_RST;

  // predictor state
  idx_t  tag_index [TABLE_DEPTH];
  slot_t slot_cnt [TABLE_DEPTH];
  slot_t peak_slots = '0;

  // generator knowledge of which tags have a map entry
  bit    gen_mapped [TABLE_DEPTH];
  tag_t  gen_tags [$];

  request_t     request_fifo [$];
  table_write_t expected_writes [$];

  int requests_queued = 0;
  int requests_taken = 0;
  int groups_taken = 0;
  int results_seen = 0;
  int settings_used = 0;
  int error_total = 0;

  initial begin
    foreach (slot_cnt[i]) slot_cnt[i] = '0;
    foreach (gen_mapped[i]) gen_mapped[i] = 1'b0;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned cap);
    return (v > cap) ? cap : v;
  endfunction

  task automatic predict_table_writes(input request_t r);
    tag_t            tags [4];
    idx_t            ids [4];
    slot_t           slots [4];
    idx_t            others [3];
    table_write_t    w;
    int unsigned     n;
    int unsigned     nt;
    int unsigned     h;
    int              k;
    logic [ST_W-1:0] st;
    n = clamp_to(cfg_pcount, TABLE_DEPTH);
    nt = clamp_to(cfg_tcount, TYPE_CAP);
    h = clamp_to(cfg_theight, HEIGHT_CAP);
    tags = '{r.tag_a, r.tag_b, r.tag_c, r.tag_d};
    case (r.req_type)
      REQ_LOAD: tag_index[r.tag_a] = r.map_index;
      REQ_CLEAR: begin
        foreach (slot_cnt[i]) slot_cnt[i] = '0;
        peak_slots = '0;
      end
      REQ_GROUP: begin
        groups_taken++;
        st = ST_OK;
        foreach (tags[i]) if (tags[i] >= n) st = ST_RANGE;
        if (st == ST_OK) begin
          for (int i = 0; i < 4; i++)
            for (int j = i + 1; j < 4; j++)
              if (tags[i] == tags[j]) st = ST_REPEAT;
        end
        if (st == ST_OK && r.group_type >= nt) st = ST_TYPE;
        if (st != ST_OK) begin
          w = '{default: '0};
          w.status = st;
          w.max_slots = peak_slots;
          w.last = 1'b1;
          expected_writes.insert(expected_writes.size(), w);
        end else begin
          // every slot is sampled before any counter moves
          for (int i = 0; i < 4; i++) begin
            ids[i] = tag_index[tags[i]];
            slots[i] = slot_cnt[ids[i]];
          end
          for (int i = 0; i < 4; i++) begin
            if (slot_cnt[ids[i]] != CNT_MAX) slot_cnt[ids[i]]++;
            if (slot_cnt[ids[i]] > peak_slots) peak_slots = slot_cnt[ids[i]];
          end
          for (int i = 0; i < 4; i++) begin
            k = 0;
            for (int j = 0; j < 4; j++) begin
              if (j != i) begin
                others[k] = ids[j];
                k++;
              end
            end
            w.write_valid = (slots[i] < h);
            w.write_addr = w.write_valid ? ADDR_W'(slots[i] * n + ids[i]) : '0;
            w.other_first = others[0];
            w.other_second = others[1];
            w.other_third = others[2];
            w.entry_type = r.group_type;
            w.member_role = ROLE_W'(i);
            w.status = w.write_valid ? ST_OK : ST_OVERFLOW;
            w.max_slots = peak_slots;
            w.last = (w.member_role == ROLE_LAST);
            expected_writes.insert(expected_writes.size(), w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver: one transaction offered at a time, held until accepted
  request_t offered;
  int       send_gap = 0;
  bit       send_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_table_writes(offered);
        requests_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_fifo.size() != 0) begin
          offered = request_fifo.pop_front();
          in_req_type <= offered.req_type;
          in_tag_a <= offered.tag_a;
          in_tag_b <= offered.tag_b;
          in_tag_c <= offered.tag_c;
          in_tag_d <= offered.tag_d;
          in_group_type <= offered.group_type;
          in_map_index <= offered.map_index;
          in_valid <= 1'b1;
          if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_wait = 0;
  int hold_left = 0;
  bit recv_burst = 1'b0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_total++;
    end
  endfunction

  always @(posedge clk) begin
    table_write_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_writes.size() == 0) begin
          $error("result with no pending expectation: status %0d addr %0d",
                 out_status, out_write_addr);
          error_total++;
        end else begin
          w = expected_writes.pop_front();
          check_field("write_valid", w.write_valid, out_write_valid);
          check_field("write_addr", w.write_addr, out_write_addr);
          check_field("other_first", w.other_first, out_other_first);
          check_field("other_second", w.other_second, out_other_second);
          check_field("other_third", w.other_third, out_other_third);
          check_field("entry_type", w.entry_type, out_entry_type);
          check_field("member_role", w.member_role, out_member_role);
          check_field("status", w.status, out_status);
          check_field("max_slots", w.max_slots, out_max_slots);
          check_field("last", w.last, out_last);
        end
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 19);
        if (results_seen == PRESSURE_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // request generation
  function automatic request_t random_request(logic [REQ_W-1:0] code);
    request_t r;
    r.req_type = code;
    r.tag_a = TAG_W'($urandom);
    r.tag_b = TAG_W'($urandom);
    r.tag_c = TAG_W'($urandom);
    r.tag_d = TAG_W'($urandom);
    r.group_type = TYPE_W'($urandom);
    r.map_index = IDX_W'($urandom);
    return r;
  endfunction

  task automatic enqueue(input request_t r);
    request_fifo.insert(request_fifo.size(), r);
    requests_queued++;
  endtask

  task automatic push_load(input tag_t tag, input idx_t index);
    request_t r;
    r = random_request(REQ_LOAD);
    r.tag_a = tag;
    r.map_index = index;
    if (!gen_mapped[tag]) begin
      gen_mapped[tag] = 1'b1;
      gen_tags.insert(gen_tags.size(), tag);
    end
    enqueue(r);
  endtask

  task automatic push_group(input tag_t a, input tag_t b, input tag_t c, input tag_t d,
                            input logic [TYPE_W-1:0] gtype);
    request_t r;
    r = random_request(REQ_GROUP);
    r.tag_a = a;
    r.tag_b = b;
    r.tag_c = c;
    r.tag_d = d;
    r.group_type = gtype;
    enqueue(r);
  endtask

  task automatic queue_random_requests(input int count);
    int unsigned     n;
    int unsigned     nt;
    int unsigned     pick;
    int unsigned     p;
    tag_t            t [4];
    tag_t            cand [$];
    logic [ST_W-1:0] fault;
    logic [TYPE_W-1:0] gtype;
    bit              dup;
    idx_t            index;
    n = clamp_to(cfg_pcount, TABLE_DEPTH);
    nt = clamp_to(cfg_tcount, TYPE_CAP);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      cand.delete();
      foreach (gen_tags[i]) if (gen_tags[i] < n) cand.insert(cand.size(), gen_tags[i]);
      if (pick >= 21 && pick < 80) begin
        if (n >= 4 && cand.size() < 4) pick = 0;
        else if (n < 4 || nt == 0) pick = 80;
      end
      if (pick < 15) begin
        if ($urandom_range(0, 9) < 7 && n > 0) t[0] = TAG_W'($urandom_range(0, n - 1));
        else t[0] = TAG_W'($urandom);
        // a small index pool makes columns fill up and overflow
        index = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
        push_load(t[0], index);
      end else if (pick < 19) begin
        enqueue(random_request(REQ_CLEAR));
      end else if (pick < 21) begin
        enqueue(random_request(REQ_UNUSED));
      end else if (pick < 80) begin
        for (int i = 0; i < 4; i++) begin
          p = $urandom_range(0, cand.size() - 1);
          t[i] = cand[p];
          cand.delete(p);
        end
        push_group(t[0], t[1], t[2], t[3], TYPE_W'($urandom_range(0, nt - 1)));
      end else begin
        case ($urandom_range(0, 2))
          0: fault = ST_RANGE;
          1: fault = ST_REPEAT;
          default: fault = ST_TYPE;
        endcase
        if (fault == ST_TYPE && (nt >= TYPE_CAP || n < 4)) fault = ST_REPEAT;
        if (fault == ST_RANGE && n >= TABLE_DEPTH) fault = ST_REPEAT;
        if (n == 0) fault = ST_RANGE;
        gtype = TYPE_W'($urandom);
        case (fault)
          ST_RANGE: begin
            foreach (t[i]) t[i] = TAG_W'($urandom);
            t[$urandom_range(0, 3)] = TAG_W'($urandom_range(n, TABLE_DEPTH - 1));
          end
          ST_REPEAT: begin
            foreach (t[i]) t[i] = TAG_W'($urandom_range(0, n - 1));
            p = $urandom_range(0, 3);
            t[(p + 1 + $urandom_range(0, 2)) % 4] = t[p];
          end
          default: begin
            for (int i = 0; i < 4; i++) begin
              dup = 1'b1;
              while (dup) begin
                t[i] = TAG_W'($urandom_range(0, n - 1));
                dup = 1'b0;
                for (int j = 0; j < i; j++) if (t[j] == t[i]) dup = 1'b1;
              end
            end
            gtype = TYPE_W'($urandom_range(nt, TYPE_CAP - 1));
          end
        endcase
        push_group(t[0], t[1], t[2], t[3], gtype);
      end
    end
  endtask

  // register access
  task automatic cfg_write(input logic [1:0] index, input int unsigned value, input int width);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= ($urandom << width) | value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input int unsigned pcount, input int unsigned tcount,
                            input int unsigned theight);
    cfg_write(REG_PCOUNT, pcount, PC_W);
    cfg_write(REG_TCOUNT, tcount, TC_W);
    cfg_write(REG_THEIGHT, theight, TH_W);
    cfg_pcount = PC_W'(pcount);
    cfg_tcount = TC_W'(tcount);
    cfg_theight = TH_W'(theight);
    settings_used++;
  endtask

  // wait until every queued request is taken and every result is back,
  // then cover a clear sweep that may still be running
  task automatic settle();
    int waited;
    waited = 0;
    @(posedge clk);
    while ((requests_taken != requests_queued || expected_writes.size() != 0) &&
           waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= SETTLE_LIMIT) begin
      $error("%0d results never arrived", expected_writes.size());
      error_total++;
      expected_writes.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  int unsigned phase_pcount [6] = '{8191, 4096, 64, 1, 1000, 4};
  int unsigned phase_tcount [6] = '{127, 64, 8, 1, 33, 64};
  int unsigned phase_theight [6] = '{31, 16, 4, 1, 9, 2};
  int          phase_items [6] = '{34, 34, 40, 14, 34, 30};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);

    set_config(4096, 64, 16);
    push_load(0, 4095);
    push_load(4095, 0);
    push_load(1, 7);
    push_load(2, 7);
    push_load(3, 7);
    push_load(4, 7);
    enqueue(random_request(REQ_UNUSED));
    push_group(0, 4095, 1, 2, 63);
    push_group(1, 2, 1, 3, 0);
    // four tags on one index: counter saturates, writes overflow
    repeat (8) push_group(1, 2, 3, 4, 5);
    enqueue(random_request(REQ_CLEAR));
    push_group(4, 3, 2, 1, 0);
    settle();

    set_config(0, 0, 0);
    push_group(0, 1, 2, 3, 0);
    settle();

    set_config(5, 0, 0);
    push_group(0, 1, 2, 3, 0);
    push_group(0, 1, 2, 5, 0);
    push_group(4, 1, 4, 2, 0);
    settle();

    set_config(4096, 64, 0);
    push_group(0, 4095, 1, 2, 17);
    settle();

    foreach (phase_items[i]) begin
      set_config(phase_pcount[i], phase_tcount[i], phase_theight[i]);
      queue_random_requests(phase_items[i]);
      settle();
    end

    if (expected_writes.size() != 0) begin
      $error("%0d expected results left over", expected_writes.size());
      error_total++;
    end
    $display("Covered %0d requests, %0d of them groups, giving %0d table results,",
             requests_taken, groups_taken, results_seen);
    $display("over %0d register settings and one %0d-cycle receiver hold-off.",
             settings_used, HOLD_CYCLES);
    if (error_total == 0) begin
      $display("four_member_adjacency_table_build verification clean");
    end else begin
      $display("four_member_adjacency_table_build verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("four_member_adjacency_table_build verification failed");
    $finish;
  end

endmodule
